// ===== design/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// Uniform triangle tessellator package
// Shared widths, the controller state type and the command and status
// words that join the controller to the datapath.
// ----------------------------------------------------------------------------
package utt_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int MAX_LEVEL   = 8;
    localparam int LEVEL_W     = 4;
    localparam int IDX_W       = $clog2(MAX_LEVEL + 1);
    localparam int NUM_W       = COORD_WIDTH + 6;
    localparam int MAG_W       = COORD_WIDTH + 5;
    localparam int CNT_W       = $clog2(MAG_W);
    localparam int AXES        = 3;
    localparam int VERTS       = 3;
    localparam int SLOT_W      = 2;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [APB_ADDR_W-3:0] REG_SPLIT_LEVEL = 1'b0;
    localparam logic [LEVEL_W-1:0]    LEVEL_RESET     = 4'd1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NUMER,
        ST_DIVIDE,
        ST_STORE,
        ST_PUSH
    } state_t;

    typedef enum logic {
        TRI_UP,
        TRI_DOWN
    } tri_kind_t;

    typedef struct packed {
        logic                capture;
        logic                numer_load;
        logic                div_step;
        logic                store;
        logic                push;
        logic                final_flag;
        logic [SLOT_W-1:0]   slot;
        logic [IDX_W-1:0]    gx;
        logic [IDX_W-1:0]    gy;
        logic [LEVEL_W-1:0]  level;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/utt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Uniform triangle tessellator controller
// Walks rows, columns, triangle orientation and vertices, and steps the
// datapath through numerator load, division, vertex store and result push.
// ----------------------------------------------------------------------------
module utt_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [utt_pkg::LEVEL_W-1:0]   split_level,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  utt_pkg::dp_status_t           status,
    output utt_pkg::dp_cmd_t              cmd
);

    utt_pkg::state_t                 state_reg, state_next;
    utt_pkg::tri_kind_t              kind_reg, kind_next;
    logic [utt_pkg::LEVEL_W-1:0]     lvl_reg, lvl_next;
    logic [utt_pkg::IDX_W-1:0]       r_reg, r_next;
    logic [utt_pkg::IDX_W-1:0]       k_reg, k_next;
    logic [utt_pkg::SLOT_W-1:0]      vi_reg, vi_next;
    logic [utt_pkg::CNT_W-1:0]       cnt_reg, cnt_next;

    logic [utt_pkg::LEVEL_W-1:0]     lvl_clamped;
    logic                            last_tri;
    logic [utt_pkg::IDX_W-1:0]       gx, gy;

    always_comb begin
        if (split_level == '0) begin
            lvl_clamped = utt_pkg::LEVEL_W'(1);
        end else if (split_level > utt_pkg::LEVEL_W'(utt_pkg::MAX_LEVEL)) begin
            lvl_clamped = utt_pkg::LEVEL_W'(utt_pkg::MAX_LEVEL);
        end else begin
            lvl_clamped = split_level;
        end
    end

    assign last_tri = (kind_reg == utt_pkg::TRI_UP) && (k_reg == r_reg)
                      && (r_reg == utt_pkg::IDX_W'(lvl_reg) - utt_pkg::IDX_W'(1));

    // Upward triangles use (r,k),(r+1,k),(r+1,k+1); downward ones use
    // (r,k+1),(r,k),(r+1,k+1).
    always_comb begin
        if (kind_reg == utt_pkg::TRI_UP) begin
            gx = r_reg + utt_pkg::IDX_W'(vi_reg != 2'd0);
            gy = k_reg + utt_pkg::IDX_W'(vi_reg == 2'd2);
        end else begin
            gx = r_reg + utt_pkg::IDX_W'(vi_reg == 2'd2);
            gy = k_reg + utt_pkg::IDX_W'(vi_reg != 2'd1);
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        lvl_next   = lvl_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        vi_next    = vi_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            utt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    lvl_next   = lvl_clamped;
                    r_next     = '0;
                    k_next     = '0;
                    kind_next  = utt_pkg::TRI_UP;
                    vi_next    = '0;
                    state_next = utt_pkg::ST_NUMER;
                end
            end
            utt_pkg::ST_NUMER: begin
                cnt_next   = utt_pkg::CNT_W'(utt_pkg::MAG_W - 1);
                state_next = utt_pkg::ST_DIVIDE;
            end
            utt_pkg::ST_DIVIDE: begin
                if (cnt_reg == '0) begin
                    state_next = utt_pkg::ST_STORE;
                end else begin
                    cnt_next = cnt_reg - utt_pkg::CNT_W'(1);
                end
            end
            utt_pkg::ST_STORE: begin
                if (vi_reg == utt_pkg::SLOT_W'(utt_pkg::VERTS - 1)) begin
                    state_next = utt_pkg::ST_PUSH;
                end else begin
                    vi_next    = vi_reg + utt_pkg::SLOT_W'(1);
                    state_next = utt_pkg::ST_NUMER;
                end
            end
            utt_pkg::ST_PUSH: begin
                if (status.out_free) begin
                    vi_next = '0;
                    if (last_tri) begin
                        state_next = utt_pkg::ST_IDLE;
                    end else begin
                        state_next = utt_pkg::ST_NUMER;
                        if (kind_reg == utt_pkg::TRI_DOWN) begin
                            kind_next = utt_pkg::TRI_UP;
                        end else if (k_reg < r_reg) begin
                            k_next    = k_reg + utt_pkg::IDX_W'(1);
                            kind_next = (k_reg + utt_pkg::IDX_W'(1) < r_reg)
                                        ? utt_pkg::TRI_DOWN : utt_pkg::TRI_UP;
                        end else begin
                            r_next    = r_reg + utt_pkg::IDX_W'(1);
                            k_next    = '0;
                            kind_next = utt_pkg::TRI_DOWN;
                        end
                    end
                end
            end
            default: begin
                state_next = utt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.slot       = vi_reg;
        cmd.gx         = gx;
        cmd.gy         = gy;
        cmd.level      = lvl_reg;
        cmd.final_flag = last_tri;
        s_ready        = 1'b0;
        case (state_reg)
            utt_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            utt_pkg::ST_NUMER: begin
                cmd.numer_load = 1'b1;
            end
            utt_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            utt_pkg::ST_STORE: begin
                cmd.store = 1'b1;
            end
            utt_pkg::ST_PUSH: begin
                cmd.push = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= utt_pkg::ST_IDLE;
            kind_reg  <= utt_pkg::TRI_UP;
            lvl_reg   <= utt_pkg::LEVEL_RESET;
            r_reg     <= '0;
            k_reg     <= '0;
            vi_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            lvl_reg   <= lvl_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
            vi_reg    <= vi_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== design/utt_datapath.sv =====
// ----------------------------------------------------------------------------
// Uniform triangle tessellator datapath
// Three axis lanes, each forming a grid numerator and dividing it by the
// level one quotient bit per cycle, plus vertex staging and the output word.
// ----------------------------------------------------------------------------
module utt_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  utt_pkg::dp_cmd_t      cmd,
    output utt_pkg::dp_status_t   status,
    input  utt_pkg::coord_t       s_corner_a_x,
    input  utt_pkg::coord_t       s_corner_a_y,
    input  utt_pkg::coord_t       s_corner_a_z,
    input  utt_pkg::coord_t       s_corner_b_x,
    input  utt_pkg::coord_t       s_corner_b_y,
    input  utt_pkg::coord_t       s_corner_b_z,
    input  utt_pkg::coord_t       s_corner_c_x,
    input  utt_pkg::coord_t       s_corner_c_y,
    input  utt_pkg::coord_t       s_corner_c_z,
    output logic                  m_valid,
    input  logic                  m_ready,
    output utt_pkg::coord_t       m_first_x,
    output utt_pkg::coord_t       m_first_y,
    output utt_pkg::coord_t       m_first_z,
    output utt_pkg::coord_t       m_second_x,
    output utt_pkg::coord_t       m_second_y,
    output utt_pkg::coord_t       m_second_z,
    output utt_pkg::coord_t       m_third_x,
    output utt_pkg::coord_t       m_third_y,
    output utt_pkg::coord_t       m_third_z,
    output logic                  m_final_piece
);

    utt_pkg::coord_t a_reg [utt_pkg::AXES];
    utt_pkg::coord_t a_next[utt_pkg::AXES];
    utt_pkg::coord_t b_reg [utt_pkg::AXES];
    utt_pkg::coord_t b_next[utt_pkg::AXES];
    utt_pkg::coord_t c_reg [utt_pkg::AXES];
    utt_pkg::coord_t c_next[utt_pkg::AXES];

    logic                          neg_reg [utt_pkg::AXES];
    logic                          neg_next[utt_pkg::AXES];
    logic [utt_pkg::LEVEL_W-1:0]   rem_reg [utt_pkg::AXES];
    logic [utt_pkg::LEVEL_W-1:0]   rem_next[utt_pkg::AXES];
    logic [utt_pkg::MAG_W-1:0]     quo_reg [utt_pkg::AXES];
    logic [utt_pkg::MAG_W-1:0]     quo_next[utt_pkg::AXES];

    utt_pkg::coord_t stage_reg [utt_pkg::VERTS][utt_pkg::AXES];
    utt_pkg::coord_t stage_next[utt_pkg::VERTS][utt_pkg::AXES];
    utt_pkg::coord_t out_reg   [utt_pkg::VERTS][utt_pkg::AXES];
    utt_pkg::coord_t out_next  [utt_pkg::VERTS][utt_pkg::AXES];
    logic            out_valid_reg, out_valid_next;
    logic            out_final_reg, out_final_next;

    logic signed [utt_pkg::NUM_W-1:0] dab  [utt_pkg::AXES];
    logic signed [utt_pkg::NUM_W-1:0] dca  [utt_pkg::AXES];
    logic signed [utt_pkg::NUM_W-1:0] num  [utt_pkg::AXES];
    logic signed [utt_pkg::NUM_W-1:0] qs   [utt_pkg::AXES];
    logic [utt_pkg::MAG_W-1:0]        mag  [utt_pkg::AXES];
    logic [utt_pkg::LEVEL_W:0]        shf  [utt_pkg::AXES];
    logic [utt_pkg::LEVEL_W:0]        sub  [utt_pkg::AXES];
    utt_pkg::coord_t                  res  [utt_pkg::AXES];
    logic signed [utt_pkg::IDX_W:0]   gx_s, gy_s;
    logic [utt_pkg::LEVEL_W:0]        lvl_ext;

    assign gx_s    = $signed({1'b0, cmd.gx});
    assign gy_s    = $signed({1'b0, cmd.gy});
    assign lvl_ext = {1'b0, cmd.level};

    // The numerator is x*(A-B) + y*(C-A); the quotient truncates toward zero
    // by dividing the magnitude and restoring the sign afterward.
    always_comb begin
        for (int d = 0; d < utt_pkg::AXES; d++) begin
            dab[d] = utt_pkg::NUM_W'(a_reg[d]) - utt_pkg::NUM_W'(b_reg[d]);
            dca[d] = utt_pkg::NUM_W'(c_reg[d]) - utt_pkg::NUM_W'(a_reg[d]);
            num[d] = dab[d] * gx_s + dca[d] * gy_s;
            mag[d] = num[d][utt_pkg::NUM_W-1] ? utt_pkg::MAG_W'(-num[d])
                                              : utt_pkg::MAG_W'(num[d]);
            shf[d] = {rem_reg[d], quo_reg[d][utt_pkg::MAG_W-1]};
            sub[d] = shf[d] - lvl_ext;
            qs[d]  = neg_reg[d] ? -$signed(utt_pkg::NUM_W'(quo_reg[d]))
                                : $signed(utt_pkg::NUM_W'(quo_reg[d]));
            res[d] = utt_pkg::COORD_WIDTH'(utt_pkg::NUM_W'(b_reg[d]) + qs[d]);
        end
    end

    always_comb begin
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        stage_next     = stage_reg;
        out_next       = out_reg;
        out_final_next = out_final_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (cmd.capture) begin
            a_next[0] = s_corner_a_x;
            a_next[1] = s_corner_a_y;
            a_next[2] = s_corner_a_z;
            b_next[0] = s_corner_b_x;
            b_next[1] = s_corner_b_y;
            b_next[2] = s_corner_b_z;
            c_next[0] = s_corner_c_x;
            c_next[1] = s_corner_c_y;
            c_next[2] = s_corner_c_z;
        end
        for (int d = 0; d < utt_pkg::AXES; d++) begin
            if (cmd.numer_load) begin
                neg_next[d] = num[d][utt_pkg::NUM_W-1];
                rem_next[d] = '0;
                quo_next[d] = mag[d];
            end else if (cmd.div_step) begin
                if (shf[d] >= lvl_ext) begin
                    rem_next[d] = sub[d][utt_pkg::LEVEL_W-1:0];
                    quo_next[d] = {quo_reg[d][utt_pkg::MAG_W-2:0], 1'b1};
                end else begin
                    rem_next[d] = shf[d][utt_pkg::LEVEL_W-1:0];
                    quo_next[d] = {quo_reg[d][utt_pkg::MAG_W-2:0], 1'b0};
                end
            end
            if (cmd.store) begin
                stage_next[cmd.slot][d] = res[d];
            end
        end
        if (cmd.push) begin
            out_next       = stage_reg;
            out_final_next = cmd.final_flag;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        neg_reg       <= neg_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        stage_reg     <= stage_next;
        out_reg       <= out_next;
        out_final_reg <= out_final_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid       = out_valid_reg;
    assign m_final_piece = out_final_reg;
    assign m_first_x     = out_reg[0][0];
    assign m_first_y     = out_reg[0][1];
    assign m_first_z     = out_reg[0][2];
    assign m_second_x    = out_reg[1][0];
    assign m_second_y    = out_reg[1][1];
    assign m_second_z    = out_reg[1][2];
    assign m_third_x     = out_reg[2][0];
    assign m_third_y     = out_reg[2][1];
    assign m_third_z     = out_reg[2][2];

endmodule

// ===== design/uniform_triangle_tessellator.sv =====
// ----------------------------------------------------------------------------
// Uniform triangle tessellator
// Splits one triangle into level squared sub-triangles on a uniform grid.
// ----------------------------------------------------------------------------
// Each accepted triangle word produces L*L sub-triangle words, L being the
// split_level register clamped to the range 1 to 8, and the last word of a
// triangle carries final_piece. Each vertex is computed by the per-axis
// divider, which retires one quotient bit per cycle over 37 bits, and a
// sub-triangle is pushed only when the output register is free. The next
// triangle is accepted once the last sub-triangle of the current one has
// been handed to the output register.
module uniform_triangle_tessellator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [utt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [utt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [utt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  utt_pkg::coord_t                   s_corner_a_x,
    input  utt_pkg::coord_t                   s_corner_a_y,
    input  utt_pkg::coord_t                   s_corner_a_z,
    input  utt_pkg::coord_t                   s_corner_b_x,
    input  utt_pkg::coord_t                   s_corner_b_y,
    input  utt_pkg::coord_t                   s_corner_b_z,
    input  utt_pkg::coord_t                   s_corner_c_x,
    input  utt_pkg::coord_t                   s_corner_c_y,
    input  utt_pkg::coord_t                   s_corner_c_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output utt_pkg::coord_t                   m_first_x,
    output utt_pkg::coord_t                   m_first_y,
    output utt_pkg::coord_t                   m_first_z,
    output utt_pkg::coord_t                   m_second_x,
    output utt_pkg::coord_t                   m_second_y,
    output utt_pkg::coord_t                   m_second_z,
    output utt_pkg::coord_t                   m_third_x,
    output utt_pkg::coord_t                   m_third_y,
    output utt_pkg::coord_t                   m_third_z,
    output logic                              m_final_piece
);

    logic [utt_pkg::LEVEL_W-1:0] split_level_reg, split_level_next;
    logic                        reg_hit;
    utt_pkg::dp_cmd_t            cmd;
    utt_pkg::dp_status_t         status;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[utt_pkg::APB_ADDR_W-1:2] == utt_pkg::REG_SPLIT_LEVEL);

    always_comb begin
        split_level_next = split_level_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            split_level_next = pwdata[utt_pkg::LEVEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_level_reg <= utt_pkg::LEVEL_RESET;
        end else begin
            split_level_reg <= split_level_next;
        end
    end

    assign prdata = reg_hit ? utt_pkg::APB_DATA_W'(split_level_reg) : '0;

    utt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .split_level (split_level_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    utt_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_corner_a_x  (s_corner_a_x),
        .s_corner_a_y  (s_corner_a_y),
        .s_corner_a_z  (s_corner_a_z),
        .s_corner_b_x  (s_corner_b_x),
        .s_corner_b_y  (s_corner_b_y),
        .s_corner_b_z  (s_corner_b_z),
        .s_corner_c_x  (s_corner_c_x),
        .s_corner_c_y  (s_corner_c_y),
        .s_corner_c_z  (s_corner_c_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_first_x     (m_first_x),
        .m_first_y     (m_first_y),
        .m_first_z     (m_first_z),
        .m_second_x    (m_second_x),
        .m_second_y    (m_second_y),
        .m_second_z    (m_second_z),
        .m_third_x     (m_third_x),
        .m_third_y     (m_third_y),
        .m_third_z     (m_third_z),
        .m_final_piece (m_final_piece)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again while a triangle is in progress");

    a_push_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> status.out_free)
        else $error("result pushed over a word not yet taken");

    a_idle_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push && cmd.final_flag |=> s_ready && m_valid && m_final_piece)
        else $error("controller did not return to idle after the final word");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.numer_load, cmd.div_step, cmd.store, cmd.push}))
        else $error("more than one datapath command in a cycle");

endmodule

// ===== sim/uniform_triangle_tessellator_tb.sv =====
// ----------------------------------------------------------------------------
// Uniform triangle tessellator testbench
// Sends triangle words through the valid/ready input and predicts every
// sub-triangle word of the uniform split at the configured level. Each
// result word is checked field by field. The split level is written over
// the APB port while the block is idle, covering the reset value, the
// clamped values 0 and above 8, and every level from 1 to 8. Both sides
// insert random gaps, and the receiver holds off long enough to stall the
// input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uniform_triangle_tessellator_tb;

    localparam logic [utt_pkg::APB_ADDR_W-1:0] SPLIT_LEVEL_ADDR =
        {utt_pkg::REG_SPLIT_LEVEL, 2'b00};
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [8:0][utt_pkg::COORD_WIDTH-1:0] c;
    } tri_t;

    typedef struct packed {
        logic                                 final_piece;
        logic [8:0][utt_pkg::COORD_WIDTH-1:0] v;
    } piece_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [utt_pkg::APB_ADDR_W-1:0] paddr;
    logic [utt_pkg::APB_DATA_W-1:0] pwdata;
    logic [utt_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_valid;
    logic                           s_ready;
    utt_pkg::coord_t                s_corner_a_x;
    utt_pkg::coord_t                s_corner_a_y;
    utt_pkg::coord_t                s_corner_a_z;
    utt_pkg::coord_t                s_corner_b_x;
    utt_pkg::coord_t                s_corner_b_y;
    utt_pkg::coord_t                s_corner_b_z;
    utt_pkg::coord_t                s_corner_c_x;
    utt_pkg::coord_t                s_corner_c_y;
    utt_pkg::coord_t                s_corner_c_z;
    logic                           m_valid;
    logic                           m_ready;
    utt_pkg::coord_t                m_first_x;
    utt_pkg::coord_t                m_first_y;
    utt_pkg::coord_t                m_first_z;
    utt_pkg::coord_t                m_second_x;
    utt_pkg::coord_t                m_second_y;
    utt_pkg::coord_t                m_second_z;
    utt_pkg::coord_t                m_third_x;
    utt_pkg::coord_t                m_third_y;
    utt_pkg::coord_t                m_third_z;
    logic                           m_final_piece;

    piece_t         expected_pieces[$];
    logic [3:0]     cfg_level;
    int             mismatch_count;
    int             triangles_sent;
    int             pieces_checked;
    int             sink_hold_cycles;
    bit             sink_stalls;
    string          piece_field[9] = '{"first_x", "first_y", "first_z",
                                       "second_x", "second_y", "second_z",
                                       "third_x", "third_y", "third_z"};

    uniform_triangle_tessellator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_corner_a_x  (s_corner_a_x),
        .s_corner_a_y  (s_corner_a_y),
        .s_corner_a_z  (s_corner_a_z),
        .s_corner_b_x  (s_corner_b_x),
        .s_corner_b_y  (s_corner_b_y),
        .s_corner_b_z  (s_corner_b_z),
        .s_corner_c_x  (s_corner_c_x),
        .s_corner_c_y  (s_corner_c_y),
        .s_corner_c_z  (s_corner_c_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_first_x     (m_first_x),
        .m_first_y     (m_first_y),
        .m_first_z     (m_first_z),
        .m_second_x    (m_second_x),
        .m_second_y    (m_second_y),
        .m_second_z    (m_second_z),
        .m_third_x     (m_third_x),
        .m_third_y     (m_third_y),
        .m_third_z     (m_third_z),
        .m_final_piece (m_final_piece)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic utt_pkg::coord_t lattice_coord(input utt_pkg::coord_t a,
                                                      input utt_pkg::coord_t b,
                                                      input utt_pkg::coord_t c,
                                                      input int x, input int y, input int lvl);
        longint numer;
        longint pos;
        numer = longint'(x) * (longint'(a) - longint'(b))
              + longint'(y) * (longint'(c) - longint'(a));
        pos = longint'(b) + numer / longint'(lvl);
        return pos[utt_pkg::COORD_WIDTH-1:0];
    endfunction

    function automatic void queue_piece(input tri_t t, input int lvl,
                                        input int x0, input int y0, input int x1, input int y1,
                                        input int x2, input int y2, input logic last);
        piece_t p;
        int     d;
        for (d = 0; d < 3; d++) begin
            p.v[d]     = lattice_coord(t.c[d], t.c[3 + d], t.c[6 + d], x0, y0, lvl);
            p.v[3 + d] = lattice_coord(t.c[d], t.c[3 + d], t.c[6 + d], x1, y1, lvl);
            p.v[6 + d] = lattice_coord(t.c[d], t.c[3 + d], t.c[6 + d], x2, y2, lvl);
        end
        p.final_piece = last;
        expected_pieces = {expected_pieces, p};
    endfunction

    function automatic void tessellate(input tri_t t);
        int lvl;
        int r;
        int k;
        lvl = int'(cfg_level);
        if (lvl < 1) begin
            lvl = 1;
        end
        if (lvl > utt_pkg::MAX_LEVEL) begin
            lvl = utt_pkg::MAX_LEVEL;
        end
        for (r = 0; r < lvl; r++) begin
            for (k = 0; k < r; k++) begin
                queue_piece(t, lvl, r, k + 1, r, k, r + 1, k + 1, 1'b0);
                queue_piece(t, lvl, r, k, r + 1, k, r + 1, k + 1, 1'b0);
            end
            queue_piece(t, lvl, r, r, r + 1, r, r + 1, r + 1, r == lvl - 1);
        end
    endfunction

    function automatic utt_pkg::coord_t random_coord();
        utt_pkg::coord_t near_zero;
        near_zero = utt_pkg::coord_t'($urandom_range(0, 4000)) - 2000;
        case ($urandom_range(0, 11))
            0: begin
                return {1'b0, {(utt_pkg::COORD_WIDTH - 1){1'b1}}};
            end
            1: begin
                return {1'b1, {(utt_pkg::COORD_WIDTH - 1){1'b0}}};
            end
            2: begin
                return '0;
            end
            3: begin
                return near_zero;
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    function automatic tri_t random_triangle();
        tri_t t;
        int   i;
        for (i = 0; i < 9; i++) begin
            t.c[i] = random_coord();
        end
        return t;
    endfunction

    function automatic tri_t corner_case(input int which);
        tri_t            t;
        int              i;
        utt_pkg::coord_t hi;
        utt_pkg::coord_t lo;
        hi = {1'b0, {(utt_pkg::COORD_WIDTH - 1){1'b1}}};
        lo = {1'b1, {(utt_pkg::COORD_WIDTH - 1){1'b0}}};
        for (i = 0; i < 9; i++) begin
            case (which)
                0: begin
                    t.c[i] = (i < 3 || i >= 6) ? hi : lo;
                end
                1: begin
                    t.c[i] = (i < 3 || i >= 6) ? lo : hi;
                end
                2: begin
                    t.c[i] = '0;
                end
                3: begin
                    // Negative numerators that do not divide evenly must truncate toward zero.
                    t.c[i] = (i < 3) ? -1 : 0;
                end
                4: begin
                    t.c[i] = (i < 3) ? 1 : ((i >= 6) ? -1 : 0);
                end
                default: begin
                    t.c[i] = (i % 2 == 0) ? hi : lo;
                end
            endcase
        end
        return t;
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(40, 150);
        end
        return $urandom_range(1, 4);
    endfunction

    task automatic apb_write(input logic [utt_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SPLIT_LEVEL_ADDR;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(output logic [utt_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SPLIT_LEVEL_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_split_level(input logic [3:0] lvl);
        logic [utt_pkg::APB_DATA_W-1:0] word;
        logic [utt_pkg::APB_DATA_W-1:0] readback;
        word = $urandom();
        word[3:0] = lvl;
        apb_write(word);
        cfg_level = lvl;
        apb_read(readback);
        if (readback !== {{(utt_pkg::APB_DATA_W - 4){1'b0}}, lvl}) begin
            $display("%0t: split_level readback expected %h, got %h",
                     $time, {{(utt_pkg::APB_DATA_W - 4){1'b0}}, lvl}, readback);
            mismatch_count++;
        end
    endtask

    task automatic send_triangle(input tri_t t);
        s_valid      <= 1'b1;
        s_corner_a_x <= t.c[0];
        s_corner_a_y <= t.c[1];
        s_corner_a_z <= t.c[2];
        s_corner_b_x <= t.c[3];
        s_corner_b_y <= t.c[4];
        s_corner_b_z <= t.c[5];
        s_corner_c_x <= t.c[6];
        s_corner_c_y <= t.c[7];
        s_corner_c_z <= t.c[8];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tessellate(t);
        triangles_sent++;
    endtask

    task automatic input_gap();
        if ($urandom_range(0, 9) >= 5) begin
            s_valid <= 1'b0;
            repeat (gap_length()) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_pieces.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [3:0] lvl, input int count, input bit gaps);
        int i;
        drain_results();
        set_split_level(lvl);
        sink_stalls = gaps;
        for (i = 0; i < count; i++) begin
            send_triangle(random_triangle());
            if ($urandom_range(0, 29) == 0) begin
                drain_results();
            end else if (gaps) begin
                input_gap();
            end
        end
    endtask

    task automatic test_reset_level();
        sink_stalls = 1'b0;
        send_triangle(corner_case(0));
        send_triangle(corner_case(5));
    endtask

    task automatic test_level_clamp();
        drain_results();
        set_split_level(4'd0);
        send_triangle(corner_case(1));
        send_triangle(random_triangle());
        drain_results();
        set_split_level(4'd9);
        send_triangle(random_triangle());
        drain_results();
        set_split_level(4'd15);
        send_triangle(corner_case(0));
    endtask

    task automatic test_corner_extremes();
        int i;
        drain_results();
        set_split_level(4'd8);
        send_triangle(corner_case(0));
        send_triangle(corner_case(1));
        drain_results();
        set_split_level(4'd3);
        for (i = 2; i < 6; i++) begin
            send_triangle(corner_case(i));
        end
        drain_results();
        set_split_level(4'd2);
        send_triangle(corner_case(3));
        send_triangle(corner_case(4));
        send_triangle(corner_case(5));
    endtask

    task automatic test_level_sweep();
        run_phase(4'd1, 60, 1'b1);
        run_phase(4'd2, 55, 1'b0);
        run_phase(4'd3, 40, 1'b1);
        run_phase(4'd4, 28, 1'b1);
        run_phase(4'd5, 10, 1'b0);
        run_phase(4'd6, 8, 1'b1);
        run_phase(4'd7, 6, 1'b1);
        run_phase(4'd8, 5, 1'b1);
    endtask

    task automatic test_output_backpressure();
        int i;
        drain_results();
        set_split_level(4'd2);
        sink_stalls = 1'b0;
        sink_hold_cycles = 3000;
        for (i = 0; i < 8; i++) begin
            send_triangle(random_triangle());
        end
        drain_results();
    endtask

    task automatic test_mixed_levels();
        int          group;
        int          pick;
        logic [3:0]  lvl;
        for (group = 0; group < 16; group++) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                lvl = 4'd0;
            end else if (pick == 1) begin
                lvl = 4'($urandom_range(9, 15));
            end else if (pick == 2) begin
                lvl = 4'($urandom_range(5, 8));
            end else begin
                lvl = 4'($urandom_range(1, 4));
            end
            run_phase(lvl, 5, group % 3 != 0);
        end
    endtask

    initial begin : result_sink
        int n;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_cycles > 0) begin
                n = sink_hold_cycles;
                sink_hold_cycles = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (sink_stalls && $urandom_range(0, 15) == 0) begin
                m_ready <= 1'b0;
                repeat (gap_length()) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : piece_check
        piece_t got;
        piece_t want;
        int     i;
        if (aresetn && m_valid && m_ready) begin
            got.v[0] = m_first_x;
            got.v[1] = m_first_y;
            got.v[2] = m_first_z;
            got.v[3] = m_second_x;
            got.v[4] = m_second_y;
            got.v[5] = m_second_z;
            got.v[6] = m_third_x;
            got.v[7] = m_third_y;
            got.v[8] = m_third_z;
            got.final_piece = m_final_piece;
            if (expected_pieces.size() == 0) begin
                $display("%0t: unexpected sub-triangle word, expected none, got %h",
                         $time, got);
                mismatch_count++;
            end else begin
                want = expected_pieces.pop_front();
                pieces_checked++;
                for (i = 0; i < 9; i++) begin
                    if (got.v[i] !== want.v[i]) begin
                        $display("%0t: %s expected %h, got %h",
                                 $time, piece_field[i], want.v[i], got.v[i]);
                        mismatch_count++;
                    end
                end
                if (got.final_piece !== want.final_piece) begin
                    $display("%0t: final_piece expected %b, got %b",
                             $time, want.final_piece, got.final_piece);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #250ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        cfg_level        = utt_pkg::LEVEL_RESET;
        mismatch_count   = 0;
        triangles_sent   = 0;
        pieces_checked   = 0;
        sink_hold_cycles = 0;
        sink_stalls      = 1'b0;
        aresetn      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        s_valid      <= 1'b0;
        s_corner_a_x <= '0;
        s_corner_a_y <= '0;
        s_corner_a_z <= '0;
        s_corner_b_x <= '0;
        s_corner_b_y <= '0;
        s_corner_b_z <= '0;
        s_corner_c_x <= '0;
        s_corner_c_y <= '0;
        s_corner_c_z <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_level();
        test_level_clamp();
        test_corner_extremes();
        test_level_sweep();
        test_output_backpressure();
        test_mixed_levels();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d triangles and checked %0d sub-triangle words at split levels 0 to 15,",
                 triangles_sent, pieces_checked);
        $display("with random gaps on both sides and a long output hold-off.");
        if (mismatch_count == 0 && expected_pieces.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
